FILE: hw/rtl/lgwa_pkg.sv
// Shared types, constants and the color aging function for the life engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lgwa_pkg;

  localparam int COLOR_W  = 4;
  localparam int COORD_W  = 3;
  localparam int HASH_W   = 18;
  localparam int COUNT_W  = 8;
  localparam int KIND_W   = 2;

  localparam logic [COLOR_W-1:0] BIRTH_COLOR = 4'h4;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'hFF;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 8'd10;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_STEP  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_SEED  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_COMMIT,
    ST_CHECK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic shift;
    logic commit;
  } cell_ctrl_t;

  // Aging chain 4,8,12,13,14,15,11,7,3,2,1; off-chain colors hold.
  function automatic logic [COLOR_W-1:0] age_next(input logic [COLOR_W-1:0] c);
    logic [COLOR_W-1:0] r;
    case (c)
      4'd0:    r = 4'd0;
      4'd1:    r = 4'd1;
      4'd2:    r = 4'd1;
      4'd3:    r = 4'd2;
      4'd4:    r = 4'd8;
      4'd5:    r = 4'd5;
      4'd6:    r = 4'd6;
      4'd7:    r = 4'd3;
      4'd8:    r = 4'd12;
      4'd9:    r = 4'd9;
      4'd10:   r = 4'd10;
      4'd11:   r = 4'd7;
      4'd12:   r = 4'd13;
      4'd13:   r = 4'd14;
      4'd14:   r = 4'd15;
      4'd15:   r = 4'd11;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lgwa_cell.sv
// One board cell of the rotating chain: current color plus next-generation lane.
// Depends on lgwa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgwa_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lgwa_pkg::cell_ctrl_t          ctrl_i,
  input  wire logic [lgwa_pkg::COLOR_W-1:0]  cur_i,
  input  wire logic [lgwa_pkg::COLOR_W-1:0]  nxt_i,
  output logic      [lgwa_pkg::COLOR_W-1:0]  cur_o,
  output logic      [lgwa_pkg::COLOR_W-1:0]  nxt_o
);

  logic [lgwa_pkg::COLOR_W-1:0] cur_q, cur_d;
  logic [lgwa_pkg::COLOR_W-1:0] nxt_q, nxt_d;

  always_comb begin
    cur_d = cur_q;
    nxt_d = nxt_q;
    if (ctrl_i.shift) begin
      cur_d = cur_i;
      nxt_d = nxt_i;
    end else if (ctrl_i.commit) begin
      cur_d = nxt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else begin
      cur_q <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nxt_q <= nxt_d;
  end

  assign cur_o = cur_q;
  assign nxt_o = nxt_q;

endmodule

`default_nettype wire

FILE: hw/rtl/lgwa_rule.sv
// Life rule with aging for the cell at the evaluation tap.
// Depends on lgwa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgwa_rule (
  input  wire logic [lgwa_pkg::COLOR_W-1:0] color_i,
  input  wire logic [7:0]                   live_i,
  output logic      [lgwa_pkg::COLOR_W-1:0] color_o
);

  logic [3:0] n;

  always_comb begin
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(live_i[i]);
    end
    if (color_i != '0) begin
      color_o = (n == 4'd2 || n == 4'd3) ? lgwa_pkg::age_next(color_i) : '0;
    end else begin
      color_o = (n == 4'd3) ? lgwa_pkg::BIRTH_COLOR : '0;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/life_generation_with_aging_top.sv
// Sequencing: a read or write rotates the cell chain once past the evaluation tap,
// a step then adds a commit and a history check, and a history reseed skips the rotation.
// Requests: a new request is taken only when idle, once the previous result is registered;
// the tap evaluates one cell per cycle.
// Reset: board clears, hash history reloads 0..HISTORY_DEPTH-1, repeat count 0,
// stall limit 10. Result register lets the next request in while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module life_generation_with_aging_top #(
  parameter int GRID_WIDTH    = 8,
  parameter int GRID_HEIGHT   = 8,
  parameter int HISTORY_DEPTH = 5
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [lgwa_pkg::COUNT_W-1:0]   cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [lgwa_pkg::KIND_W-1:0]    kind_i,
  input  wire logic [lgwa_pkg::COORD_W-1:0]   cell_col_i,
  input  wire logic [lgwa_pkg::COORD_W-1:0]   cell_row_i,
  input  wire logic [lgwa_pkg::COLOR_W-1:0]   cell_color_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [lgwa_pkg::COLOR_W-1:0]   read_color_o,
  output logic      [lgwa_pkg::HASH_W-1:0]    board_hash_o,
  output logic      [lgwa_pkg::COUNT_W-1:0]   repeat_count_o,
  output logic                                stalled_o
);

  localparam int N    = GRID_WIDTH * GRID_HEIGHT;
  localparam int W    = GRID_WIDTH;
  localparam int XW   = $clog2(GRID_WIDTH);
  localparam int YW   = $clog2(GRID_HEIGHT);
  localparam int PW   = $clog2(N);
  localparam int CW   = (XW > YW ? XW : YW) > lgwa_pkg::COORD_W ?
                        (XW > YW ? XW : YW) : lgwa_pkg::COORD_W;
  localparam int HW   = lgwa_pkg::HASH_W;
  localparam int T_UL = N - W - 1;
  localparam int T_U  = N - W;
  localparam int T_UR = N - W + 1;
  localparam int T_L  = N - 1;
  localparam int T_R  = 1;
  localparam int T_DL = W - 1;
  localparam int T_D  = W;
  localparam int T_DR = W + 1;
  localparam logic [XW-1:0] X_LAST = XW'(GRID_WIDTH - 1);
  localparam logic [YW-1:0] Y_LAST = YW'(GRID_HEIGHT - 1);

  lgwa_pkg::state_e state_q, state_d;
  lgwa_pkg::kind_e  kind_q;
  logic [lgwa_pkg::COORD_W-1:0] col_q, row_q;
  logic [lgwa_pkg::COLOR_W-1:0] color_q;

  logic [XW-1:0] x_q;
  logic [YW-1:0] y_q;
  logic [PW-1:0] prod_q;
  logic [HW-1:0] acc_q;
  logic [lgwa_pkg::COLOR_W-1:0] rd_q;

  logic [HW-1:0] hist_q [HISTORY_DEPTH];
  logic [lgwa_pkg::COUNT_W-1:0] rc_q;
  logic [lgwa_pkg::COUNT_W-1:0] limit_q;

  logic                         out_valid_q;
  logic [lgwa_pkg::COLOR_W-1:0] out_rd_q;
  logic [HW-1:0]                out_hash_q;
  logic [lgwa_pkg::COUNT_W-1:0] out_rc_q;
  logic                         out_stl_q;

  lgwa_pkg::cell_ctrl_t ctrl;
  logic [lgwa_pkg::COLOR_W-1:0] cur_w [N];
  logic [lgwa_pkg::COLOR_W-1:0] nxt_w [N];
  logic [lgwa_pkg::COLOR_W-1:0] tail_cur, tail_nxt;
  logic [7:0] live;
  logic up_ok, dn_ok, lf_ok, rt_ok;
  logic last_cell, hit, accept, load_out, match;

  assign accept    = in_valid_i && !in_stall_o;
  assign last_cell = (x_q == X_LAST) && (y_q == Y_LAST);
  assign hit       = (CW'(x_q) == CW'(col_q)) && (CW'(y_q) == CW'(row_q));
  assign load_out  = (state_q == lgwa_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  assign ctrl = '{shift:  (state_q == lgwa_pkg::ST_RUN),
                  commit: (state_q == lgwa_pkg::ST_COMMIT)};

  // Cell 0 is the evaluation tap; neighbors sit at fixed offsets in the ring.
  assign up_ok = (y_q != '0);
  assign dn_ok = (y_q != Y_LAST);
  assign lf_ok = (x_q != '0);
  assign rt_ok = (x_q != X_LAST);

  always_comb begin
    live[0] = (cur_w[T_UL] != '0) && up_ok && lf_ok;
    live[1] = (cur_w[T_U]  != '0) && up_ok;
    live[2] = (cur_w[T_UR] != '0) && up_ok && rt_ok;
    live[3] = (cur_w[T_L]  != '0) && lf_ok;
    live[4] = (cur_w[T_R]  != '0) && rt_ok;
    live[5] = (cur_w[T_DL] != '0) && dn_ok && lf_ok;
    live[6] = (cur_w[T_D]  != '0) && dn_ok;
    live[7] = (cur_w[T_DR] != '0) && dn_ok && rt_ok;
  end

  lgwa_rule u_rule (
    .color_i (cur_w[0]),
    .live_i  (live),
    .color_o (tail_nxt)
  );

  assign tail_cur = (kind_q == lgwa_pkg::KIND_WRITE && hit) ? color_q : cur_w[0];

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == N - 1) begin : g_tail
      lgwa_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl),
        .cur_i  (tail_cur),
        .nxt_i  (tail_nxt),
        .cur_o  (cur_w[i]),
        .nxt_o  (nxt_w[i])
      );
    end else begin : g_body
      lgwa_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl),
        .cur_i  (cur_w[i+1]),
        .nxt_i  (nxt_w[i+1]),
        .cur_o  (cur_w[i]),
        .nxt_o  (nxt_w[i])
      );
    end
  end

  always_comb begin
    match = 1'b0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      for (int j = i + 1; j < HISTORY_DEPTH; j++) begin
        if (hist_q[i] == hist_q[j]) match = 1'b1;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    case (state_q)
      lgwa_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = (lgwa_pkg::kind_e'(kind_i) == lgwa_pkg::KIND_SEED) ?
                    lgwa_pkg::ST_DONE : lgwa_pkg::ST_RUN;
        end
      end
      lgwa_pkg::ST_RUN: begin
        if (last_cell) begin
          state_d = (kind_q == lgwa_pkg::KIND_STEP) ? lgwa_pkg::ST_COMMIT : lgwa_pkg::ST_DONE;
        end
      end
      lgwa_pkg::ST_COMMIT: state_d = lgwa_pkg::ST_CHECK;
      lgwa_pkg::ST_CHECK:  state_d = lgwa_pkg::ST_DONE;
      lgwa_pkg::ST_DONE: begin
        if (load_out) state_d = lgwa_pkg::ST_IDLE;
      end
      default: state_d = lgwa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lgwa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= lgwa_pkg::kind_e'(kind_i);
      col_q   <= cell_col_i;
      row_q   <= cell_row_i;
      color_q <= cell_color_i;
      x_q     <= '0;
      y_q     <= '0;
      prod_q  <= '0;
      acc_q   <= '0;
      rd_q    <= '0;
    end else if (state_q == lgwa_pkg::ST_RUN) begin
      if (kind_q == lgwa_pkg::KIND_READ && hit) rd_q <= cur_w[0];
      if (tail_nxt != '0) acc_q <= acc_q + HW'(prod_q);
      if (x_q == X_LAST) begin
        x_q    <= '0;
        y_q    <= (y_q == Y_LAST) ? '0 : y_q + 1'b1;
        prod_q <= '0;
      end else begin
        x_q    <= x_q + 1'b1;
        prod_q <= prod_q + PW'(y_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] <= HW'(i);
      rc_q    <= '0;
      limit_q <= lgwa_pkg::LIMIT_RESET;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (accept && lgwa_pkg::kind_e'(kind_i) == lgwa_pkg::KIND_SEED) begin
        for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] <= HW'(i);
      end else if (state_q == lgwa_pkg::ST_COMMIT) begin
        for (int i = HISTORY_DEPTH - 1; i > 0; i--) hist_q[i] <= hist_q[i-1];
        hist_q[0] <= acc_q;
      end
      if (state_q == lgwa_pkg::ST_CHECK) begin
        if (!match) rc_q <= '0;
        else if (rc_q != lgwa_pkg::COUNT_MAX) rc_q <= rc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_rd_q   <= rd_q;
      out_hash_q <= hist_q[0];
      out_rc_q   <= rc_q;
      out_stl_q  <= (rc_q >= limit_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_color_o   = out_rd_q;
  assign board_hash_o   = out_hash_q;
  assign repeat_count_o = out_rc_q;
  assign stalled_o      = out_stl_q;

endmodule

`default_nettype wire

FILE: hw/rtl/lgwa_checker.sv
// Port-level checks for life_generation_with_aging_top, bound to the top level.
// Depends on lgwa_pkg and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module lgwa_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          cfg_we_i,
  input wire logic [lgwa_pkg::COUNT_W-1:0]  cfg_wdata_i,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [lgwa_pkg::HASH_W-1:0]   board_hash_o,
  input wire logic [lgwa_pkg::COUNT_W-1:0]  repeat_count_o,
  input wire logic                          stalled_o
);

  logic [lgwa_pkg::COUNT_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= lgwa_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(board_hash_o) && $stable(repeat_count_o))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while previous one in flight");

  a_stall_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && !$past(cfg_we_i) |-> stalled_o == (repeat_count_o >= limit_q))
    else $error("stalled flag disagrees with repeat count and limit");

endmodule

bind life_generation_with_aging_top lgwa_checker u_lgwa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cfg_we_i       (cfg_we_i),
  .cfg_wdata_i    (cfg_wdata_i),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .board_hash_o   (board_hash_o),
  .repeat_count_o (repeat_count_o),
  .stalled_o      (stalled_o)
);

`default_nettype wire

FILE: tb/tb_life_generation_with_aging_top.sv
// Testbench for life_generation_with_aging_top: directed table then random requests,
// every result checked against typed table values or a behavioral board model. Depends on lgwa_pkg.
`timescale 1ns / 1ps

module tb_life_generation_with_aging_top;

  localparam int CLK_PERIOD     = 12;
  localparam int GRID_W         = 8;
  localparam int GRID_H         = 8;
  localparam int HIST_DEPTH     = 5;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 600;
  localparam int DRAIN_CYCLES   = 80;
  localparam int ERR_PRINT_MAX  = 40;
  localparam int DIR_ROWS       = 25;

  // next color of a survivor, indexed by current color
  localparam logic [63:0] AGE_NEXT = {4'd11, 4'd15, 4'd14, 4'd13, 4'd7, 4'd10, 4'd9, 4'd12,
                                      4'd3, 4'd6, 4'd5, 4'd8, 4'd2, 4'd1, 4'd1, 4'd0};

  typedef struct packed {
    lgwa_pkg::kind_e                kind;
    logic [lgwa_pkg::COORD_W-1:0]   col;
    logic [lgwa_pkg::COORD_W-1:0]   row;
    logic [lgwa_pkg::COLOR_W-1:0]   color;
  } life_req_t;

  typedef struct packed {
    logic [lgwa_pkg::COLOR_W-1:0]   rd;
    logic [lgwa_pkg::HASH_W-1:0]    hash;
    logic [lgwa_pkg::COUNT_W-1:0]   cnt;
    logic                           st;
  } life_result_t;

  typedef struct packed {
    lgwa_pkg::kind_e                kind;
    logic [lgwa_pkg::COORD_W-1:0]   col;
    logic [lgwa_pkg::COORD_W-1:0]   row;
    logic [lgwa_pkg::COLOR_W-1:0]   color;
    logic                           typed;
    logic [lgwa_pkg::COLOR_W-1:0]   rd;
    logic [lgwa_pkg::HASH_W-1:0]    hash;
    logic [lgwa_pkg::COUNT_W-1:0]   cnt;
    logic                           st;
  } dir_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [lgwa_pkg::COUNT_W-1:0]   cfg_wdata;
  logic                           in_valid;
  logic                           in_stall;
  logic                           out_valid;
  logic                           out_stall;
  logic [lgwa_pkg::COLOR_W-1:0]   read_color;
  logic [lgwa_pkg::HASH_W-1:0]    board_hash;
  logic [lgwa_pkg::COUNT_W-1:0]   repeat_count;
  logic                           stalled;

  life_req_t                      cur_req;
  logic                           cur_typed;
  life_result_t                   cur_typed_res;

  // board model state
  logic [lgwa_pkg::COLOR_W-1:0]   cells [GRID_H][GRID_W];
  logic [lgwa_pkg::HASH_W-1:0]    hash_hist [HIST_DEPTH];
  logic [lgwa_pkg::COUNT_W-1:0]   repeat_q;
  logic [lgwa_pkg::COUNT_W-1:0]   stall_limit_q;

  life_result_t         pending_results [$];
  int                   fail_count;
  bit                   quiet;
  bit                   long_hold_req;
  int                   hold_left;
  dir_row_t             dir_rows [DIR_ROWS];

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  life_generation_with_aging_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (cur_req.kind),
    .cell_col_i     (cur_req.col),
    .cell_row_i     (cur_req.row),
    .cell_color_i   (cur_req.color),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .read_color_o   (read_color),
    .board_hash_o   (board_hash),
    .repeat_count_o (repeat_count),
    .stalled_o      (stalled)
  );

  function automatic life_result_t apply_request(input life_req_t r);
    logic [lgwa_pkg::COLOR_W-1:0] next_cells [GRID_H][GRID_W];
    logic [lgwa_pkg::HASH_W-1:0]  h;
    int                           x, y, dx, dy, nx, ny, i, j, n;
    bit                           hit;
    life_result_t                 res;
    res = '0;
    case (r.kind)
      lgwa_pkg::KIND_WRITE: cells[r.row][r.col] = r.color;
      lgwa_pkg::KIND_READ:  res.rd = cells[r.row][r.col];
      lgwa_pkg::KIND_SEED: begin
        for (i = 0; i < HIST_DEPTH; i++) hash_hist[i] = lgwa_pkg::HASH_W'(i);
      end
      default: begin
        h = '0;
        for (y = 0; y < GRID_H; y++) begin
          for (x = 0; x < GRID_W; x++) begin
            n = 0;
            for (dy = -1; dy <= 1; dy++) begin
              for (dx = -1; dx <= 1; dx++) begin
                nx = x + dx;
                ny = y + dy;
                if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0 && nx < GRID_W && ny < GRID_H)
                  if (cells[ny][nx] != 0) n++;
              end
            end
            if (cells[y][x] != 0)
              next_cells[y][x] = (n == 2 || n == 3) ? AGE_NEXT[cells[y][x]*4 +: 4] : '0;
            else
              next_cells[y][x] = (n == 3) ? lgwa_pkg::BIRTH_COLOR : '0;
          end
        end
        for (y = 0; y < GRID_H; y++) begin
          for (x = 0; x < GRID_W; x++) begin
            cells[y][x] = next_cells[y][x];
            if (next_cells[y][x] != 0) h = h + lgwa_pkg::HASH_W'(x * y);
          end
        end
        for (i = HIST_DEPTH - 1; i > 0; i--) hash_hist[i] = hash_hist[i-1];
        hash_hist[0] = h;
        hit = 1'b0;
        for (i = 0; i < HIST_DEPTH; i++)
          for (j = i + 1; j < HIST_DEPTH; j++)
            if (hash_hist[i] == hash_hist[j]) hit = 1'b1;
        if (!hit) repeat_q = '0;
        else if (repeat_q != lgwa_pkg::COUNT_MAX) repeat_q = repeat_q + 1'b1;
      end
    endcase
    res.hash = hash_hist[0];
    res.cnt  = repeat_q;
    res.st   = (repeat_q >= stall_limit_q);
    return res;
  endfunction

  task automatic report_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      fail_count++;
      if (fail_count <= ERR_PRINT_MAX)
        $error("%s expected %0d got %0d", name, exp_v, act_v);
    end
  endtask

  // requests are predicted on acceptance, results checked in order
  always @(posedge clk_i) begin
    life_result_t predicted;
    life_result_t exp_res;
    if (in_fire) begin
      predicted = apply_request(cur_req);
      pending_results.push_back(cur_typed ? cur_typed_res : predicted);
    end
    if (out_fire) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $error("result with no pending request");
      end else begin
        exp_res = pending_results.pop_front();
        report_field("read_color", int'(exp_res.rd), int'(read_color));
        report_field("board_hash", int'(exp_res.hash), int'(board_hash));
        report_field("repeat_count", int'(exp_res.cnt), int'(repeat_count));
        report_field("stalled", int'(exp_res.st), int'(stalled));
      end
    end
  end

  // receiver: random stall bursts plus one long hold on request
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_stall = 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < 12) begin
        hold_left = $urandom_range(1, 11) - 1;
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_request(input life_req_t r, input logic typed, input life_result_t tres);
    if (!quiet && $urandom_range(0, 99) < 20) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    cur_req       = r;
    cur_typed     = typed;
    cur_typed_res = tres;
    in_valid      = 1'b1;
    @(posedge clk_i);
    while (!in_fire) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_stall_limit(input logic [lgwa_pkg::COUNT_W-1:0] value);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we        = 1'b0;
    stall_limit_q = value;
  endtask

  task automatic run_random(input int count, input int step_pct, input int seed_pct,
                            input int write_pct, input int hold_at);
    life_req_t r;
    int        pick;
    int        k;
    for (k = 0; k < count; k++) begin
      if (k == hold_at) long_hold_req = 1'b1;
      pick    = $urandom_range(0, 99);
      r.col   = 3'($urandom_range(0, 7));
      r.row   = 3'($urandom_range(0, 7));
      r.color = 4'($urandom_range(0, 15));
      if (pick < seed_pct) r.kind = lgwa_pkg::KIND_SEED;
      else if (pick < seed_pct + step_pct) r.kind = lgwa_pkg::KIND_STEP;
      else if (pick < seed_pct + step_pct + write_pct) r.kind = lgwa_pkg::KIND_WRITE;
      else r.kind = lgwa_pkg::KIND_READ;
      send_request(r, 1'b0, '0);
    end
  endtask

  initial begin
    int        k, y, x;
    life_req_t r;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    cur_req       = '0;
    cur_typed     = 1'b0;
    cur_typed_res = '0;
    quiet         = 1'b0;
    long_hold_req = 1'b0;
    fail_count    = 0;
    for (y = 0; y < GRID_H; y++)
      for (x = 0; x < GRID_W; x++) cells[y][x] = '0;
    for (k = 0; k < HIST_DEPTH; k++) hash_hist[k] = lgwa_pkg::HASH_W'(k);
    repeat_q      = '0;
    stall_limit_q = lgwa_pkg::LIMIT_RESET;

    // block still life with off-chain and chain colors, lone corner cell,
    // vertical blinker, then kills and isolated off-chain cells
    dir_rows = '{
      '{lgwa_pkg::KIND_READ,  3'd0, 3'd0, 4'd0,  1'b1, 4'd0,  18'd0, 8'd0, 1'b0},
      '{lgwa_pkg::KIND_READ,  3'd7, 3'd7, 4'd15, 1'b1, 4'd0,  18'd0, 8'd0, 1'b0},
      '{lgwa_pkg::KIND_WRITE, 3'd7, 3'd7, 4'd15, 1'b1, 4'd0,  18'd0, 8'd0, 1'b0},
      '{lgwa_pkg::KIND_READ,  3'd7, 3'd7, 4'd0,  1'b1, 4'd15, 18'd0, 8'd0, 1'b0},
      '{lgwa_pkg::KIND_WRITE, 3'd0, 3'd0, 4'd5,  1'b1, 4'd0,  18'd0, 8'd0, 1'b0},
      '{lgwa_pkg::KIND_WRITE, 3'd1, 3'd0, 4'd4,  1'b1, 4'd0,  18'd0, 8'd0, 1'b0},
      '{lgwa_pkg::KIND_WRITE, 3'd0, 3'd1, 4'd9,  1'b1, 4'd0,  18'd0, 8'd0, 1'b0},
      '{lgwa_pkg::KIND_WRITE, 3'd1, 3'd1, 4'd1,  1'b1, 4'd0,  18'd0, 8'd0, 1'b0},
      '{lgwa_pkg::KIND_STEP,  3'd0, 3'd0, 4'd0,  1'b0, 4'd0,  18'd0, 8'd0, 1'b0},
      '{lgwa_pkg::KIND_READ,  3'd0, 3'd0, 4'd0,  1'b0, 4'd0,  18'd0, 8'd0, 1'b0},
      '{lgwa_pkg::KIND_READ,  3'd1, 3'd0, 4'd0,  1'b0, 4'd0,  18'd0, 8'd0, 1'b0},
      '{lgwa_pkg::KIND_READ,  3'd1, 3'd1, 4'd0,  1'b0, 4'd0,  18'd0, 8'd0, 1'b0},
      '{lgwa_pkg::KIND_READ,  3'd7, 3'd7, 4'd0,  1'b0, 4'd0,  18'd0, 8'd0, 1'b0},
      '{lgwa_pkg::KIND_SEED,  3'd0, 3'd0, 4'd0,  1'b0, 4'd0,  18'd0, 8'd0, 1'b0},
      '{lgwa_pkg::KIND_WRITE, 3'd4, 3'd3, 4'd12, 1'b0, 4'd0,  18'd0, 8'd0, 1'b0},
      '{lgwa_pkg::KIND_WRITE, 3'd4, 3'd4, 4'd12, 1'b0, 4'd0,  18'd0, 8'd0, 1'b0},
      '{lgwa_pkg::KIND_WRITE, 3'd4, 3'd5, 4'd12, 1'b0, 4'd0,  18'd0, 8'd0, 1'b0},
      '{lgwa_pkg::KIND_STEP,  3'd7, 3'd7, 4'd15, 1'b0, 4'd0,  18'd0, 8'd0, 1'b0},
      '{lgwa_pkg::KIND_STEP,  3'd0, 3'd0, 4'd0,  1'b0, 4'd0,  18'd0, 8'd0, 1'b0},
      '{lgwa_pkg::KIND_READ,  3'd3, 3'd4, 4'd0,  1'b0, 4'd0,  18'd0, 8'd0, 1'b0},
      '{lgwa_pkg::KIND_READ,  3'd4, 3'd3, 4'd0,  1'b0, 4'd0,  18'd0, 8'd0, 1'b0},
      '{lgwa_pkg::KIND_WRITE, 3'd0, 3'd0, 4'd0,  1'b0, 4'd0,  18'd0, 8'd0, 1'b0},
      '{lgwa_pkg::KIND_WRITE, 3'd7, 3'd0, 4'd10, 1'b0, 4'd0,  18'd0, 8'd0, 1'b0},
      '{lgwa_pkg::KIND_WRITE, 3'd0, 3'd7, 4'd6,  1'b0, 4'd0,  18'd0, 8'd0, 1'b0},
      '{lgwa_pkg::KIND_STEP,  3'd0, 3'd0, 4'd0,  1'b0, 4'd0,  18'd0, 8'd0, 1'b0}
    };

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;
    @(negedge clk_i);

    for (k = 0; k < DIR_ROWS; k++) begin
      r.kind  = dir_rows[k].kind;
      r.col   = dir_rows[k].col;
      r.row   = dir_rows[k].row;
      r.color = dir_rows[k].color;
      send_request(r, dir_rows[k].typed,
                   {dir_rows[k].rd, dir_rows[k].hash, dir_rows[k].cnt, dir_rows[k].st});
    end

    set_stall_limit(8'd1);
    run_random(350, 35, 5, 30, 50);
    // mostly steps so the board settles and the repeat count saturates
    set_stall_limit(8'd255);
    run_random(400, 92, 0, 0, -1);
    set_stall_limit(8'd0);
    run_random(200, 40, 5, 30, -1);
    set_stall_limit(8'($urandom_range(2, 254)));
    run_random(230, 35, 4, 35, -1);
    set_stall_limit(8'($urandom_range(2, 254)));
    run_random(230, 50, 6, 25, -1);
    set_stall_limit(8'($urandom_range(1, 6)));
    quiet = 1'b1;
    run_random(230, 45, 5, 30, -1);

    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      fail_count++;
      $error("%0d results never arrived", pending_results.size());
    end
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
